FILE: hdl/lts_pkg.sv
// Shared types and constants for the Lisp token scanner.
package lts_pkg;

  localparam int unsigned CpW = 21;

  localparam logic [CpW-1:0] ChColon = CpW'(8'h3A);
  localparam logic [CpW-1:0] ChLowA  = CpW'(8'h61);
  localparam logic [CpW-1:0] ChLowZ  = CpW'(8'h7A);
  localparam logic [CpW-1:0] ChUpA   = CpW'(8'h41);
  localparam logic [CpW-1:0] ChUpZ   = CpW'(8'h5A);

  typedef enum logic [2:0] {
    ST_ILLEGAL    = 3'd0,
    ST_WHITESPACE = 3'd1,
    ST_TERM_MACRO = 3'd2,
    ST_NTERM_MACRO = 3'd3,
    ST_SINGLE_ESC = 3'd4,
    ST_MULTI_ESC  = 3'd5,
    ST_CONSTITUENT = 3'd6
  } stype_e;

  typedef enum logic [2:0] {
    EV_PUSH      = 3'd0,
    EV_PACKAGE   = 3'd1,
    EV_TOKEN_END = 3'd2,
    EV_MACRO     = 3'd3,
    EV_EOF       = 3'd4,
    EV_ILLEGAL   = 3'd5,
    EV_BAD       = 3'd6,
    EV_COLON     = 3'd7
  } event_e;

  typedef enum logic [1:0] {
    CASE_UP       = 2'd0,
    CASE_DOWN     = 2'd1,
    CASE_PRESERVE = 2'd2,
    CASE_INVERT   = 2'd3
  } case_e;

  typedef enum logic [1:0] {
    PK_KEYWORD  = 2'd0,
    PK_ESCAPED  = 2'd1,
    PK_CLASSIFY = 2'd2
  } pkg_kind_e;

  // Classified item as it travels from front to back.
  typedef struct packed {
    logic           eof;
    logic [2:0]     stype;
    logic [CpW-1:0] code_point;
    logic [CpW-1:0] cased;
    logic           is_colon;
  } entry_t;

  // One result item.
  typedef struct packed {
    logic [2:0]     ev;
    logic [CpW-1:0] ch;
    logic           esc;
    logic           put_back;
    logic [1:0]     pkg_kind;
    logic           internal_ref;
    logic           token_escaped;
  } result_t;

endpackage

FILE: hdl/lts_front.sv
// Front stage: takes items, decodes colon and readtable case, registers them.
module lts_front (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      kind_i,
  input  logic [lts_pkg::CpW-1:0]   code_point_i,
  input  logic [2:0]                syntax_type_i,
  input  logic [1:0]                case_mode_i,
  input  logic                      q_full_i,
  output logic                      entry_valid_o,
  output lts_pkg::entry_t           entry_o
);

  logic            valid_q, valid_d;
  lts_pkg::entry_t entry_q, entry_d;
  logic            accept, push;
  logic            is_lower, is_upper, flip;

  assign in_stall_o = valid_q & q_full_i;
  assign accept     = in_valid_i & ~in_stall_o;
  assign push       = valid_q & ~q_full_i;
  assign valid_d    = accept | (valid_q & ~push);

  assign is_lower = (code_point_i >= lts_pkg::ChLowA) && (code_point_i <= lts_pkg::ChLowZ);
  assign is_upper = (code_point_i >= lts_pkg::ChUpA) && (code_point_i <= lts_pkg::ChUpZ);

  always_comb begin
    case (lts_pkg::case_e'(case_mode_i))
      lts_pkg::CASE_UP:       flip = is_lower;
      lts_pkg::CASE_DOWN:     flip = is_upper;
      lts_pkg::CASE_PRESERVE: flip = 1'b0;
      lts_pkg::CASE_INVERT:   flip = is_lower | is_upper;
      default:                flip = 1'b0;
    endcase
  end

  always_comb begin
    entry_d.eof        = kind_i;
    entry_d.stype      = syntax_type_i;
    entry_d.code_point = code_point_i;
    // ASCII letters differ in case by bit 5 only
    entry_d.cased      = code_point_i ^ {{(lts_pkg::CpW-6){1'b0}}, flip, 5'b0};
    entry_d.is_colon   = (code_point_i == lts_pkg::ChColon);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      entry_q <= entry_d;
    end
  end

  assign entry_valid_o = valid_q;
  assign entry_o       = entry_q;

endmodule

FILE: hdl/lts_fifo.sv
// Two-entry queue between front and back.
module lts_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_valid_i,
  input  lts_pkg::entry_t push_i,
  output logic            full_o,
  output logic            head_valid_o,
  output lts_pkg::entry_t head_o,
  input  logic            pop_i
);

  lts_pkg::entry_t mem_q [2];
  logic            wr_ptr_q, rd_ptr_q;
  logic [1:0]      count_q, count_d;
  logic            push, pop;

  assign full_o       = (count_q == 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];
  assign push         = push_valid_i & ~full_o;
  assign pop          = pop_i & head_valid_o;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i;
    end
  end

endmodule

FILE: hdl/lts_back.sv
// Back stage: token scanner state machine and result register.
module lts_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            head_valid_i,
  input  lts_pkg::entry_t head_i,
  output logic            pop_o,
  input  logic            preserve_ws_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output lts_pkg::result_t result_o
);

  typedef enum logic [2:0] {
    PH_BETWEEN   = 3'd0,
    PH_ESC_START = 3'd1,
    PH_IN_TOKEN  = 3'd2,
    PH_ESC_TOKEN = 3'd3,
    PH_MULTI     = 3'd4,
    PH_MULTI_ESC = 3'd5
  } phase_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_FAIL,
    ACT_MACRO,
    ACT_TOKEN_END,
    ACT_PUSH_ESC,
    ACT_PUSH_PLAIN
  } act_e;

  localparam logic [1:0] ColNone  = 2'd0;
  localparam logic [1:0] ColOne   = 2'd1;
  localparam logic [1:0] ColAfter = 2'd2;

  phase_e           phase_q, phase_d;
  logic [1:0]       colon_q, colon_d;
  logic             esc_seen_q, esc_seen_d;
  logic             internal_q, internal_d;
  logic             nonempty_q, nonempty_d;
  logic             out_valid_q;
  lts_pkg::result_t result_q, res;
  logic             emit, go;
  act_e             act;
  lts_pkg::event_e  fail_ev;
  logic             fail_ch, pb;

  assign go    = head_valid_i & (~out_valid_q | ~out_stall_i);
  assign pop_o = go;

  always_comb begin
    phase_d    = phase_q;
    colon_d    = colon_q;
    esc_seen_d = esc_seen_q;
    internal_d = internal_q;
    nonempty_d = nonempty_q;
    act        = ACT_NONE;
    fail_ev    = lts_pkg::EV_BAD;
    fail_ch    = 1'b0;
    pb         = 1'b0;
    emit       = 1'b0;
    res        = '0;

    case (phase_q)
      PH_BETWEEN: begin
        if (head_i.eof) begin
          act     = ACT_FAIL;
          fail_ev = lts_pkg::EV_EOF;
        end else begin
          case (lts_pkg::stype_e'(head_i.stype))
            lts_pkg::ST_ILLEGAL: begin
              act     = ACT_FAIL;
              fail_ev = lts_pkg::EV_ILLEGAL;
              fail_ch = 1'b1;
            end
            lts_pkg::ST_WHITESPACE:  act = ACT_NONE;
            lts_pkg::ST_TERM_MACRO,
            lts_pkg::ST_NTERM_MACRO: act = ACT_MACRO;
            lts_pkg::ST_SINGLE_ESC:  phase_d = PH_ESC_START;
            lts_pkg::ST_MULTI_ESC:   phase_d = PH_MULTI;
            lts_pkg::ST_CONSTITUENT: begin
              phase_d = PH_IN_TOKEN;
              act     = ACT_PUSH_PLAIN;
            end
            default: act = ACT_FAIL;
          endcase
        end
      end
      PH_ESC_START, PH_ESC_TOKEN: begin
        if (head_i.eof) begin
          act = ACT_FAIL;
        end else begin
          phase_d = PH_IN_TOKEN;
          act     = ACT_PUSH_ESC;
        end
      end
      PH_IN_TOKEN: begin
        if (head_i.eof) begin
          act = ACT_TOKEN_END;
        end else begin
          case (lts_pkg::stype_e'(head_i.stype))
            lts_pkg::ST_ILLEGAL: begin
              act     = ACT_FAIL;
              fail_ev = lts_pkg::EV_ILLEGAL;
              fail_ch = 1'b1;
            end
            lts_pkg::ST_WHITESPACE: begin
              act = ACT_TOKEN_END;
              pb  = preserve_ws_i;
            end
            lts_pkg::ST_TERM_MACRO: begin
              act = ACT_TOKEN_END;
              pb  = 1'b1;
            end
            lts_pkg::ST_NTERM_MACRO,
            lts_pkg::ST_CONSTITUENT: act = ACT_PUSH_PLAIN;
            lts_pkg::ST_SINGLE_ESC:  phase_d = PH_ESC_TOKEN;
            lts_pkg::ST_MULTI_ESC:   phase_d = PH_MULTI;
            default: act = ACT_FAIL;
          endcase
        end
      end
      PH_MULTI: begin
        if (head_i.eof) begin
          act = ACT_FAIL;
        end else begin
          case (lts_pkg::stype_e'(head_i.stype))
            lts_pkg::ST_ILLEGAL: begin
              act     = ACT_FAIL;
              fail_ev = lts_pkg::EV_ILLEGAL;
              fail_ch = 1'b1;
            end
            lts_pkg::ST_WHITESPACE,
            lts_pkg::ST_TERM_MACRO,
            lts_pkg::ST_NTERM_MACRO,
            lts_pkg::ST_CONSTITUENT: act = ACT_PUSH_ESC;
            lts_pkg::ST_SINGLE_ESC:  phase_d = PH_MULTI_ESC;
            lts_pkg::ST_MULTI_ESC:   phase_d = PH_IN_TOKEN;
            default: act = ACT_FAIL;
          endcase
        end
      end
      PH_MULTI_ESC: begin
        if (head_i.eof) begin
          act = ACT_FAIL;
        end else begin
          phase_d = PH_MULTI;
          act     = ACT_PUSH_ESC;
        end
      end
      default: act = ACT_FAIL;
    endcase

    case (act)
      ACT_NONE: emit = 1'b0;
      ACT_FAIL: begin
        phase_d    = PH_BETWEEN;
        colon_d    = ColNone;
        esc_seen_d = 1'b0;
        internal_d = 1'b0;
        nonempty_d = 1'b0;
        emit       = 1'b1;
        res.ev     = fail_ev;
        res.ch     = fail_ch ? head_i.code_point : '0;
      end
      ACT_MACRO: begin
        phase_d      = PH_BETWEEN;
        colon_d      = ColNone;
        esc_seen_d   = 1'b0;
        internal_d   = 1'b0;
        nonempty_d   = 1'b0;
        emit         = 1'b1;
        res.ev       = lts_pkg::EV_MACRO;
        res.ch       = head_i.code_point;
        res.put_back = 1'b1;
      end
      ACT_TOKEN_END: begin
        phase_d           = PH_BETWEEN;
        colon_d           = ColNone;
        esc_seen_d        = 1'b0;
        internal_d        = 1'b0;
        nonempty_d        = 1'b0;
        emit              = 1'b1;
        res.ev            = lts_pkg::EV_TOKEN_END;
        res.put_back      = pb;
        res.internal_ref  = internal_q;
        res.token_escaped = esc_seen_q;
      end
      ACT_PUSH_ESC: begin
        esc_seen_d = 1'b1;
        if (colon_q == ColOne) begin
          colon_d = ColAfter;
        end
        nonempty_d = 1'b1;
        emit       = 1'b1;
        res.ev     = lts_pkg::EV_PUSH;
        res.ch     = head_i.code_point;
        res.esc    = 1'b1;
      end
      ACT_PUSH_PLAIN: begin
        // plain push unless the colon logic takes the character
        nonempty_d = 1'b1;
        emit       = 1'b1;
        res.ev     = lts_pkg::EV_PUSH;
        res.ch     = head_i.cased;
        if (colon_q == ColNone) begin
          internal_d = 1'b0;
          if (head_i.is_colon) begin
            colon_d    = ColOne;
            nonempty_d = 1'b0;
            res.ev     = lts_pkg::EV_PACKAGE;
            res.ch     = '0;
            res.pkg_kind = esc_seen_q ? lts_pkg::PK_ESCAPED :
                           (nonempty_q ? lts_pkg::PK_CLASSIFY : lts_pkg::PK_KEYWORD);
          end
        end else if (colon_q == ColOne) begin
          colon_d = ColAfter;
          if (head_i.is_colon) begin
            // double colon: internal symbol, nothing emitted
            internal_d = 1'b1;
            nonempty_d = nonempty_q;
            emit       = 1'b0;
          end
        end else if (head_i.is_colon) begin
          phase_d    = PH_BETWEEN;
          colon_d    = ColNone;
          esc_seen_d = 1'b0;
          internal_d = 1'b0;
          nonempty_d = 1'b0;
          res.ev     = lts_pkg::EV_COLON;
          res.ch     = '0;
        end
      end
      default: emit = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_BETWEEN;
      colon_q     <= ColNone;
      esc_seen_q  <= 1'b0;
      internal_q  <= 1'b0;
      nonempty_q  <= 1'b0;
      out_valid_q <= 1'b0;
      result_q    <= '0;
    end else begin
      if (go) begin
        phase_q    <= phase_d;
        colon_q    <= colon_d;
        esc_seen_q <= esc_seen_d;
        internal_q <= internal_d;
        nonempty_q <= nonempty_d;
      end
      if (go && emit) begin
        out_valid_q <= 1'b1;
        result_q    <= res;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = result_q;

endmodule

FILE: hdl/lisp_token_scanner_core.sv
// Top level of the Lisp token scanner: config registers, front, queue, back.
//
// Lisp token scanner. Each input item is one character with its readtable
// syntax type already looked up, or an end-of-input mark (kind_i = 1). The
// block runs the reader's token steps: it skips whitespace between tokens,
// reports macro characters, handles single and multiple escapes, tracks the
// package colon and the double-colon (internal) flag, and applies the
// readtable case to unescaped ASCII letters. Each item gives zero or one
// result item; last_o is always 1. Throughput is one item per clock cycle
// when neither side stalls: the scanner state update in the back stage is
// decided combinationally, and a two-entry queue between the classifying
// front register and the back stage lets either side stall on its own. An
// accepted item passes through the front register, then the queue and
// then the result register. Registers on the APB port: 0x0 case_mode
// (0 upcase, 1 downcase, 2 preserve, 3 invert), 0x4 preserve_whitespace.
// Write them only while the block is idle.
module lisp_token_scanner_core (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // config port
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [2:0]              paddr,
  input  logic [31:0]             pwdata,
  output logic [31:0]             prdata,
  output logic                    pready,
  // input items
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic                    kind_i,
  input  logic [lts_pkg::CpW-1:0] code_point_i,
  input  logic [2:0]              syntax_type_i,
  // result items
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [2:0]              event_res_o,
  output logic [lts_pkg::CpW-1:0] out_char_o,
  output logic                    char_escaped_o,
  output logic                    put_back_o,
  output logic [1:0]              package_kind_o,
  output logic                    internal_ref_o,
  output logic                    token_escaped_o,
  output logic                    last_o
);

  logic [1:0]       case_mode_q;
  logic             preserve_ws_q;
  logic             cfg_wr;

  logic             front_valid;
  lts_pkg::entry_t  front_entry;
  logic             q_full;
  logic             head_valid;
  lts_pkg::entry_t  head;
  logic             pop;
  lts_pkg::result_t result;

  // register index sits in paddr[2]; low address bits are ignored
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = paddr[2] ? {31'b0, preserve_ws_q} : {30'b0, case_mode_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      case_mode_q   <= lts_pkg::CASE_UP;
      preserve_ws_q <= 1'b0;
    end else if (cfg_wr) begin
      if (paddr[2]) begin
        preserve_ws_q <= pwdata[0];
      end else begin
        case_mode_q <= pwdata[1:0];
      end
    end
  end

  lts_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .code_point_i  (code_point_i),
    .syntax_type_i (syntax_type_i),
    .case_mode_i   (case_mode_q),
    .q_full_i      (q_full),
    .entry_valid_o (front_valid),
    .entry_o       (front_entry)
  );

  lts_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (front_valid),
    .push_i       (front_entry),
    .full_o       (q_full),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  lts_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .preserve_ws_i (preserve_ws_q),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_o      (result)
  );

  assign event_res_o     = result.ev;
  assign out_char_o      = result.ch;
  assign char_escaped_o  = result.esc;
  assign put_back_o      = result.put_back;
  assign package_kind_o  = result.pkg_kind;
  assign internal_ref_o  = result.internal_ref;
  assign token_escaped_o = result.token_escaped;
  assign last_o          = 1'b1;

endmodule
